FILE: src/aicr_pkg.sv
// Shared constants, types and header offsets of the ARP and ICMP echo responder.
package aicr_pkg;

    localparam int HOLD_BYTES = 42;
    localparam int IDX_W = $clog2(HOLD_BYTES);
    localparam int CNT_W = $clog2(HOLD_BYTES + 1);

    localparam int MAC_W = 48;
    localparam int IP_W = 32;
    localparam int PORT_W = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MY_MAC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MY_IP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVICE_PORT = 2'd2;

    localparam int OFF_ETH_SRC = 6;
    localparam int OFF_ETYPE = 12;
    localparam int OFF_ARP_OP = 20;
    localparam int OFF_ARP_SHA = 22;
    localparam int OFF_IP_PROTO = 23;
    localparam int OFF_IP_SRC = 26;
    localparam int OFF_ARP_SPA = 28;
    localparam int OFF_IP_DST = 30;
    localparam int OFF_ARP_THA = 32;
    localparam int OFF_ICMP_TYPE = 34;
    localparam int OFF_UDP_DPORT = 36;
    localparam int OFF_ARP_TPA = 38;

    localparam logic [15:0] ETYPE_ARP = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [7:0] ARP_OP_REPLY_LO = 8'h02;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

    typedef enum logic [2:0] {
        VERDICT_REPLY      = 3'd0,
        VERDICT_DROP       = 3'd1,
        VERDICT_NO_HANDLER = 3'd2,
        VERDICT_SERVICE    = 3'd3,
        VERDICT_OTHER_UDP  = 3'd4,
        VERDICT_RUNT       = 3'd5
    } verdict_t;

    typedef struct packed {
        logic             is_burst;
        logic [7:0]       data;
        logic             last;
        verdict_t         verdict;
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             is_arp;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    typedef struct packed {
        logic             we;
        logic             bank;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] idx;
    } ram_rd_t;

endpackage

FILE: src/aicr_hold_ram.sv
// Two-bank header hold memory with one write port and one registered read port.
module aicr_hold_ram (
    input  logic               clk,
    input  aicr_pkg::ram_wr_t  wr,
    input  aicr_pkg::ram_rd_t  rd,
    output logic [7:0]         rdata
);

    logic [7:0] mem [0:1][0:aicr_pkg::HOLD_BYTES-1];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.bank][wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata <= mem[rd.bank][rd.idx];
        end
    end

endmodule

FILE: src/aicr_desc_fifo.sv
// Two-entry descriptor queue between the front and back parts.
module aicr_desc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  aicr_pkg::desc_t     wr_desc,
    input  logic                rd_en,
    output aicr_pkg::desc_t     head,
    output logic                q_full,
    output logic                q_empty
);

    aicr_pkg::desc_t entry_reg [0:1];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_comb
    begin
        wp_next = wp_reg ^ wr_en;
        rp_next = rp_reg ^ rd_en;
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wp_reg] <= wr_desc;
        end
    end

    assign head = entry_reg[rp_reg];
    assign q_full = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);

endmodule

FILE: src/aicr_front.sv
// Front part: accepts frame bytes, fills the hold banks, classifies and queues work.
module aicr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    pkt_byte,
    input  logic                          pkt_last,
    input  logic [aicr_pkg::IP_W-1:0]     my_ip,
    input  logic [aicr_pkg::PORT_W-1:0]   service_port,
    input  logic                          q_full,
    output logic                          q_push,
    output aicr_pkg::desc_t               q_desc,
    output aicr_pkg::ram_wr_t             ram_wr,
    input  aicr_pkg::bank_release_t       release_in
);

    typedef struct packed {
        logic [15:0] etype;
        logic [15:0] arp_op;
        logic [31:0] arp_tpa;
        logic [7:0]  proto;
        logic [31:0] ip_dst;
        logic [7:0]  icmp_type;
        logic [15:0] udp_dport;
    } fields_t;

    logic [aicr_pkg::CNT_W-1:0] pos_reg;
    logic [aicr_pkg::CNT_W-1:0] pos_next;
    logic                       wbank_reg;
    logic                       wbank_next;
    logic [1:0]                 busy_reg;
    logic [1:0]                 busy_next;
    aicr_pkg::verdict_t         fv_reg;
    aicr_pkg::verdict_t         fv_next;
    fields_t                    fields_reg;
    fields_t                    fields_next;
    logic                       holding;
    logic                       accept;
    logic [aicr_pkg::CNT_W-1:0] pos_inc;
    aicr_pkg::verdict_t         decision;

    function automatic logic [7:0] pick(input logic [aicr_pkg::CNT_W-1:0] pos,
                                        input int off, input logic [7:0] b,
                                        input logic [7:0] old);
        logic [7:0] r;
        r = old;
        if (pos == aicr_pkg::CNT_W'(off))
        begin
            r = b;
        end
        return r;
    endfunction

    assign holding = (pos_reg != aicr_pkg::CNT_W'(aicr_pkg::HOLD_BYTES));
    assign full = q_full || (holding && busy_reg[wbank_reg]);
    assign accept = push && !full;
    assign pos_inc = pos_reg + aicr_pkg::CNT_W'(1);

    always_comb
    begin
        fields_next = fields_reg;
        if (accept && holding)
        begin
            fields_next.etype[15:8] = pick(pos_reg, aicr_pkg::OFF_ETYPE, pkt_byte,
                                           fields_reg.etype[15:8]);
            fields_next.etype[7:0] = pick(pos_reg, aicr_pkg::OFF_ETYPE + 1, pkt_byte,
                                          fields_reg.etype[7:0]);
            fields_next.arp_op[15:8] = pick(pos_reg, aicr_pkg::OFF_ARP_OP, pkt_byte,
                                            fields_reg.arp_op[15:8]);
            fields_next.arp_op[7:0] = pick(pos_reg, aicr_pkg::OFF_ARP_OP + 1, pkt_byte,
                                           fields_reg.arp_op[7:0]);
            fields_next.proto = pick(pos_reg, aicr_pkg::OFF_IP_PROTO, pkt_byte,
                                     fields_reg.proto);
            fields_next.icmp_type = pick(pos_reg, aicr_pkg::OFF_ICMP_TYPE, pkt_byte,
                                         fields_reg.icmp_type);
            fields_next.udp_dport[15:8] = pick(pos_reg, aicr_pkg::OFF_UDP_DPORT, pkt_byte,
                                               fields_reg.udp_dport[15:8]);
            fields_next.udp_dport[7:0] = pick(pos_reg, aicr_pkg::OFF_UDP_DPORT + 1,
                                              pkt_byte, fields_reg.udp_dport[7:0]);
            for (int i = 0; i < 4; i++)
            begin
                fields_next.arp_tpa[31-8*i -: 8] = pick(pos_reg, aicr_pkg::OFF_ARP_TPA + i,
                                                        pkt_byte,
                                                        fields_reg.arp_tpa[31-8*i -: 8]);
                fields_next.ip_dst[31-8*i -: 8] = pick(pos_reg, aicr_pkg::OFF_IP_DST + i,
                                                       pkt_byte,
                                                       fields_reg.ip_dst[31-8*i -: 8]);
            end
        end
    end

    always_comb
    begin
        priority if (fields_next.etype == aicr_pkg::ETYPE_ARP)
        begin
            if (fields_next.arp_tpa == my_ip && fields_next.arp_op == aicr_pkg::ARP_OP_REQUEST)
            begin
                decision = aicr_pkg::VERDICT_REPLY;
            end
            else
            begin
                decision = aicr_pkg::VERDICT_DROP;
            end
        end
        else if (fields_next.etype == aicr_pkg::ETYPE_IPV4
                 && fields_next.proto == aicr_pkg::PROTO_UDP)
        begin
            if (fields_next.udp_dport == service_port)
            begin
                decision = aicr_pkg::VERDICT_SERVICE;
            end
            else
            begin
                decision = aicr_pkg::VERDICT_OTHER_UDP;
            end
        end
        else if (fields_next.etype == aicr_pkg::ETYPE_IPV4
                 && fields_next.proto == aicr_pkg::PROTO_ICMP)
        begin
            if (fields_next.icmp_type == aicr_pkg::ICMP_ECHO_REQUEST
                && fields_next.ip_dst == my_ip)
            begin
                decision = aicr_pkg::VERDICT_REPLY;
            end
            else
            begin
                decision = aicr_pkg::VERDICT_DROP;
            end
        end
        else
        begin
            decision = aicr_pkg::VERDICT_NO_HANDLER;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        wbank_next = wbank_reg;
        busy_next = busy_reg;
        fv_next = fv_reg;
        q_push = 1'b0;
        q_desc.is_burst = 1'b0;
        q_desc.data = pkt_byte;
        q_desc.last = pkt_last;
        q_desc.verdict = fv_reg;
        q_desc.bank = wbank_reg;
        q_desc.count = pos_inc;
        q_desc.is_arp = (fields_next.etype == aicr_pkg::ETYPE_ARP);
        ram_wr.we = accept && holding;
        ram_wr.bank = wbank_reg;
        ram_wr.idx = pos_reg[aicr_pkg::IDX_W-1:0];
        ram_wr.data = pkt_byte;

        if (release_in.valid)
        begin
            busy_next[release_in.bank] = 1'b0;
        end

        if (accept)
        begin
            if (!holding)
            begin
                q_push = 1'b1;
                if (pkt_last)
                begin
                    pos_next = '0;
                end
            end
            else if (pos_inc == aicr_pkg::CNT_W'(aicr_pkg::HOLD_BYTES) || pkt_last)
            begin
                q_push = 1'b1;
                q_desc.is_burst = 1'b1;
                if (pos_inc == aicr_pkg::CNT_W'(aicr_pkg::HOLD_BYTES))
                begin
                    q_desc.verdict = decision;
                end
                else
                begin
                    q_desc.verdict = aicr_pkg::VERDICT_RUNT;
                end
                fv_next = q_desc.verdict;
                busy_next[wbank_reg] = 1'b1;
                wbank_next = !wbank_reg;
                pos_next = pkt_last ? '0 : pos_inc;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            wbank_reg <= 1'b0;
            busy_reg <= 2'b00;
            fv_reg <= aicr_pkg::VERDICT_REPLY;
        end
        else
        begin
            pos_reg <= pos_next;
            wbank_reg <= wbank_next;
            busy_reg <= busy_next;
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fields_reg <= fields_next;
    end

endmodule

FILE: src/aicr_back.sv
// Back part: walks queued work, rewrites reply headers and buffers results.
module aicr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [aicr_pkg::MAC_W-1:0]    my_mac,
    input  logic [aicr_pkg::IP_W-1:0]     my_ip,
    input  aicr_pkg::desc_t               head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output aicr_pkg::ram_rd_t             ram_rd,
    input  logic [7:0]                    ram_rdata,
    output aicr_pkg::bank_release_t       release_out,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          out_last,
    output logic [2:0]                    verdict
);

    logic [aicr_pkg::IDX_W-1:0] k_reg;
    logic [aicr_pkg::IDX_W-1:0] k_next;
    logic                       st_v_reg;
    logic                       st_sel_mem_reg;
    logic [7:0]                 st_byte_reg;
    logic                       st_last_reg;
    aicr_pkg::verdict_t         st_verdict_reg;
    logic [7:0]                 ob_byte_reg [0:1];
    logic                       ob_last_reg [0:1];
    aicr_pkg::verdict_t         ob_verdict_reg [0:1];
    logic                       ob_wp_reg;
    logic                       ob_rp_reg;
    logic [1:0]                 ob_cnt_reg;
    logic [1:0]                 ob_cnt_next;
    logic [1:0]                 occ;
    logic                       out_pop;
    logic                       issue;
    logic                       final_elem;
    logic                       rewrite;
    logic                       sel_mem;
    logic [7:0]                 sub_byte;
    logic [aicr_pkg::IDX_W-1:0] rd_idx;

    function automatic logic in_range(input logic [aicr_pkg::IDX_W-1:0] k,
                                      input int lo, input int len);
        return (k >= aicr_pkg::IDX_W'(lo)) && (k < aicr_pkg::IDX_W'(lo + len));
    endfunction

    function automatic logic [7:0] mac_byte(input logic [aicr_pkg::MAC_W-1:0] v,
                                            input logic [aicr_pkg::IDX_W-1:0] j);
        logic [aicr_pkg::MAC_W-1:0] sh;
        sh = v << {j, 3'b000};
        return sh[aicr_pkg::MAC_W-1 -: 8];
    endfunction

    function automatic logic [7:0] ip_byte(input logic [aicr_pkg::IP_W-1:0] v,
                                           input logic [aicr_pkg::IDX_W-1:0] j);
        logic [aicr_pkg::IP_W-1:0] sh;
        sh = v << {j, 3'b000};
        return sh[aicr_pkg::IP_W-1 -: 8];
    endfunction

    assign out_pop = pop && !empty;
    assign occ = ob_cnt_reg - {1'b0, out_pop} + {1'b0, st_v_reg};
    assign issue = !q_empty && (occ < 2'd2);
    assign final_elem = !head.is_burst
                        || (aicr_pkg::CNT_W'(k_reg) == head.count - aicr_pkg::CNT_W'(1));
    assign rewrite = head.is_burst && (head.verdict == aicr_pkg::VERDICT_REPLY);

    always_comb
    begin
        rd_idx = k_reg;
        sel_mem = head.is_burst;
        sub_byte = head.data;
        if (rewrite)
        begin
            if (in_range(k_reg, 0, 6))
            begin
                rd_idx = k_reg + aicr_pkg::IDX_W'(aicr_pkg::OFF_ETH_SRC);
            end
            else if (in_range(k_reg, aicr_pkg::OFF_ETH_SRC, 6))
            begin
                sel_mem = 1'b0;
                sub_byte = mac_byte(my_mac, k_reg - aicr_pkg::IDX_W'(aicr_pkg::OFF_ETH_SRC));
            end
            else if (head.is_arp)
            begin
                if (in_range(k_reg, aicr_pkg::OFF_ARP_OP, 1))
                begin
                    sel_mem = 1'b0;
                    sub_byte = 8'h00;
                end
                else if (in_range(k_reg, aicr_pkg::OFF_ARP_OP + 1, 1))
                begin
                    sel_mem = 1'b0;
                    sub_byte = aicr_pkg::ARP_OP_REPLY_LO;
                end
                else if (in_range(k_reg, aicr_pkg::OFF_ARP_SHA, 6))
                begin
                    sel_mem = 1'b0;
                    sub_byte = mac_byte(my_mac,
                                        k_reg - aicr_pkg::IDX_W'(aicr_pkg::OFF_ARP_SHA));
                end
                else if (in_range(k_reg, aicr_pkg::OFF_ARP_SPA, 4))
                begin
                    sel_mem = 1'b0;
                    sub_byte = ip_byte(my_ip, k_reg - aicr_pkg::IDX_W'(aicr_pkg::OFF_ARP_SPA));
                end
                else if (in_range(k_reg, aicr_pkg::OFF_ARP_THA, 10))
                begin
                    rd_idx = k_reg
                             - aicr_pkg::IDX_W'(aicr_pkg::OFF_ARP_THA - aicr_pkg::OFF_ARP_SHA);
                end
            end
            else
            begin
                if (in_range(k_reg, aicr_pkg::OFF_IP_SRC, 4))
                begin
                    sel_mem = 1'b0;
                    sub_byte = ip_byte(my_ip, k_reg - aicr_pkg::IDX_W'(aicr_pkg::OFF_IP_SRC));
                end
                else if (in_range(k_reg, aicr_pkg::OFF_IP_DST, 4))
                begin
                    rd_idx = k_reg
                             - aicr_pkg::IDX_W'(aicr_pkg::OFF_IP_DST - aicr_pkg::OFF_IP_SRC);
                end
                else if (in_range(k_reg, aicr_pkg::OFF_ICMP_TYPE, 1))
                begin
                    sel_mem = 1'b0;
                    sub_byte = aicr_pkg::ICMP_ECHO_REPLY;
                end
            end
        end
    end

    always_comb
    begin
        k_next = k_reg;
        if (issue && head.is_burst)
        begin
            k_next = final_elem ? '0 : k_reg + aicr_pkg::IDX_W'(1);
        end
        q_pop = issue && final_elem;
        release_out.valid = issue && head.is_burst && final_elem;
        release_out.bank = head.bank;
        ram_rd.en = issue && sel_mem;
        ram_rd.bank = head.bank;
        ram_rd.idx = rd_idx;
        ob_cnt_next = ob_cnt_reg - {1'b0, out_pop} + {1'b0, st_v_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            st_v_reg <= 1'b0;
            ob_wp_reg <= 1'b0;
            ob_rp_reg <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            k_reg <= k_next;
            st_v_reg <= issue;
            ob_wp_reg <= ob_wp_reg ^ st_v_reg;
            ob_rp_reg <= ob_rp_reg ^ out_pop;
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            st_sel_mem_reg <= sel_mem;
            st_byte_reg <= sub_byte;
            st_last_reg <= head.last && final_elem;
            st_verdict_reg <= head.verdict;
        end
        if (st_v_reg)
        begin
            ob_byte_reg[ob_wp_reg] <= st_sel_mem_reg ? ram_rdata : st_byte_reg;
            ob_last_reg[ob_wp_reg] <= st_last_reg;
            ob_verdict_reg[ob_wp_reg] <= st_verdict_reg;
        end
    end

    assign empty = (ob_cnt_reg == 2'd0);
    assign out_byte = ob_byte_reg[ob_rp_reg];
    assign out_last = ob_last_reg[ob_rp_reg];
    assign verdict = ob_verdict_reg[ob_rp_reg];

endmodule

FILE: src/arp_icmp_responder_classifier_core.sv
// Top level of the ARP and ICMP echo responder and frame classifier.
//
// Frame bytes enter through a queue-style port: a transaction is taken when push
// is high and full is low, with pkt_last marking the final byte of a frame.
// Results leave through a queue-style port: the oldest result is shown while empty
// is low and is taken when pop is high. Configuration writes use cfg_valid and
// cfg_ready (always high) with cfg_index selecting my_mac, my_ip or service_port.
// The first 42 bytes of each frame are held in one of two memory banks; when the
// hold is full, or the frame ends early, the whole held header is emitted as a
// burst, one byte per cycle, rewritten into a reply where one is due. Later bytes
// pass straight through. One byte is accepted and one result delivered per cycle
// in steady state. A burst's first byte passes the descriptor queue, the back
// part's staging register, fed by the hold memory's registered read port, and its
// output buffer. Header bytes stall while both banks await emission, all input
// while the work queue is full. When the receiver stops popping, results collect
// in a two-entry output buffer and the back part pauses. Reset clears all control
// state and the configuration registers; no memory clearing pass is needed.
module arp_icmp_responder_classifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          pkt_byte,
    input  logic                                pkt_last,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          out_byte,
    output logic                                out_last,
    output logic [2:0]                          verdict,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aicr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aicr_pkg::MAC_W-1:0]          cfg_data
);

    logic [aicr_pkg::MAC_W-1:0]  my_mac_reg;
    logic [aicr_pkg::IP_W-1:0]   my_ip_reg;
    logic [aicr_pkg::PORT_W-1:0] service_port_reg;

    logic                    q_full;
    logic                    q_empty;
    logic                    q_push;
    logic                    q_pop;
    aicr_pkg::desc_t         q_desc;
    aicr_pkg::desc_t         q_head;
    aicr_pkg::ram_wr_t       ram_wr;
    aicr_pkg::ram_rd_t       ram_rd;
    logic [7:0]              ram_rdata;
    aicr_pkg::bank_release_t bank_release;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_mac_reg <= '0;
            my_ip_reg <= '0;
            service_port_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                aicr_pkg::CFG_MY_MAC: my_mac_reg <= cfg_data;
                aicr_pkg::CFG_MY_IP: my_ip_reg <= cfg_data[aicr_pkg::IP_W-1:0];
                aicr_pkg::CFG_SERVICE_PORT: service_port_reg <= cfg_data[aicr_pkg::PORT_W-1:0];
                default: ;
            endcase
        end
    end

    aicr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pkt_byte     (pkt_byte),
        .pkt_last     (pkt_last),
        .my_ip        (my_ip_reg),
        .service_port (service_port_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_desc       (q_desc),
        .ram_wr       (ram_wr),
        .release_in   (bank_release)
    );

    aicr_desc_fifo u_desc_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_desc (q_desc),
        .rd_en   (q_pop),
        .head    (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    aicr_hold_ram u_hold_ram (
        .clk   (clk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    aicr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .my_mac      (my_mac_reg),
        .my_ip       (my_ip_reg),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .ram_rd      (ram_rd),
        .ram_rdata   (ram_rdata),
        .release_out (bank_release),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .verdict     (verdict)
    );

endmodule
